[hw/rtl/matrix_inverse_3x3_macros.svh]
// ----------------------------------------------------------------------------
// matrix_inverse_3x3 assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MATRIX_INVERSE_3X3_MACROS_SVH
`define MATRIX_INVERSE_3X3_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MI3_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MI3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/mi3_pkg.sv]
// ----------------------------------------------------------------------------
// mi3_pkg
// Types, widths and cofactor wiring shared by the 3x3 matrix inverse.
// ----------------------------------------------------------------------------
package mi3_pkg;

    localparam int ELEM_W = 32;
    localparam int FRAC_W = 16;
    localparam int LANES  = 9;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int COF_W  = 2 * ELEM_W + 1;
    localparam int PART_W = 2 * ELEM_W + 1;
    localparam int DET_W  = 3 * ELEM_W + 3;
    localparam int NUM_W  = COF_W + 2 * FRAC_W;
    localparam int QB     = ELEM_W + 1;
    localparam int CMP_W  = DET_W + QB + 1;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic signed [ELEM_W:0]   t_half;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [COF_W-1:0]  t_cof;
    typedef logic signed [PART_W-1:0] t_part;
    typedef logic signed [DET_W-1:0]  t_det;
    typedef logic [DET_W-1:0]         t_den;
    typedef logic [COF_W-1:0]         t_mag;
    typedef logic [NUM_W-1:0]         t_num;
    typedef logic [QB-1:0]            t_quo;
    typedef logic [CMP_W-1:0]         t_cmp;

    typedef struct packed {
        t_elem m00;
        t_elem m01;
        t_elem m02;
        t_elem m10;
        t_elem m11;
        t_elem m12;
        t_elem m20;
        t_elem m21;
        t_elem m22;
    } t_in_item;

    typedef struct packed {
        t_elem inv00;
        t_elem inv01;
        t_elem inv02;
        t_elem inv10;
        t_elem inv11;
        t_elem inv12;
        t_elem inv20;
        t_elem inv21;
        t_elem inv22;
        logic  singular;
        logic  overflow;
    } t_out_item;

    // Adjugate entry l is m[a]*m[b] - m[c]*m[d], negated where COF_FLIP is set.
    localparam int COF_IDX [LANES][4] = '{
        '{4, 8, 7, 5}, '{1, 8, 7, 2}, '{1, 5, 4, 2},
        '{3, 8, 6, 5}, '{0, 8, 6, 2}, '{0, 5, 3, 2},
        '{3, 7, 6, 4}, '{0, 7, 6, 1}, '{0, 4, 3, 1}
    };
    localparam logic [LANES-1:0] COF_FLIP = 9'b010101010;

endpackage

[hw/rtl/mi3_cofactor.sv]
// ----------------------------------------------------------------------------
// mi3_cofactor
// Two stages: the eighteen pair products, then the nine signed cofactors.
// ----------------------------------------------------------------------------
module mi3_cofactor (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  logic                                    i_valid,
    input  mi3_pkg::t_in_item                       i_item,
    output logic                                    o_valid,
    output mi3_pkg::t_cof [mi3_pkg::LANES-1:0]      o_cof,
    output mi3_pkg::t_elem [2:0]                    o_row0
);

    mi3_pkg::t_elem                       w_m [mi3_pkg::LANES];
    mi3_pkg::t_prod                       n_pa [mi3_pkg::LANES];
    mi3_pkg::t_prod                       n_pb [mi3_pkg::LANES];
    mi3_pkg::t_prod                       r_pa [mi3_pkg::LANES];
    mi3_pkg::t_prod                       r_pb [mi3_pkg::LANES];
    mi3_pkg::t_elem [2:0]                 r_row0_a;
    mi3_pkg::t_elem [2:0]                 r_row0_b;
    mi3_pkg::t_cof [mi3_pkg::LANES-1:0]   n_cof;
    mi3_pkg::t_cof [mi3_pkg::LANES-1:0]   r_cof;
    logic                                 r_va;
    logic                                 r_vb;

    assign w_m[0] = i_item.m00;
    assign w_m[1] = i_item.m01;
    assign w_m[2] = i_item.m02;
    assign w_m[3] = i_item.m10;
    assign w_m[4] = i_item.m11;
    assign w_m[5] = i_item.m12;
    assign w_m[6] = i_item.m20;
    assign w_m[7] = i_item.m21;
    assign w_m[8] = i_item.m22;

    always_comb begin
        for (int l = 0; l < mi3_pkg::LANES; l++) begin
            n_pa[l] = mi3_pkg::t_prod'(w_m[mi3_pkg::COF_IDX[l][0]])
                    * mi3_pkg::t_prod'(w_m[mi3_pkg::COF_IDX[l][1]]);
            n_pb[l] = mi3_pkg::t_prod'(w_m[mi3_pkg::COF_IDX[l][2]])
                    * mi3_pkg::t_prod'(w_m[mi3_pkg::COF_IDX[l][3]]);
        end
    end

    always_comb begin
        for (int l = 0; l < mi3_pkg::LANES; l++) begin
            if (mi3_pkg::COF_FLIP[l]) begin
                n_cof[l] = mi3_pkg::t_cof'(r_pb[l]) - mi3_pkg::t_cof'(r_pa[l]);
            end else begin
                n_cof[l] = mi3_pkg::t_cof'(r_pa[l]) - mi3_pkg::t_cof'(r_pb[l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa     <= n_pa;
            r_pb     <= n_pb;
            r_row0_a <= {w_m[2], w_m[1], w_m[0]};
            r_cof    <= n_cof;
            r_row0_b <= r_row0_a;
        end
    end

    assign o_valid = r_vb;
    assign o_cof   = r_cof;
    assign o_row0  = r_row0_b;

endmodule

[hw/rtl/mi3_det.sv]
// ----------------------------------------------------------------------------
// mi3_det
// Determinant by expansion along row 0, then magnitudes and signs for the
// dividers. Three stages: split products, sum, absolute values.
// ----------------------------------------------------------------------------
module mi3_det (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  logic                                    i_valid,
    input  mi3_pkg::t_cof [mi3_pkg::LANES-1:0]      i_cof,
    input  mi3_pkg::t_elem [2:0]                    i_row0,
    output logic                                    o_valid,
    output mi3_pkg::t_den                           o_den,
    output mi3_pkg::t_num [mi3_pkg::LANES-1:0]      o_num,
    output logic [mi3_pkg::LANES-1:0]               o_neg,
    output logic                                    o_zero
);

    mi3_pkg::t_half                       w_lo [3];
    mi3_pkg::t_half                       w_hi [3];
    mi3_pkg::t_part                       n_plo [3];
    mi3_pkg::t_part                       n_phi [3];
    mi3_pkg::t_part                       r_plo [3];
    mi3_pkg::t_part                       r_phi [3];
    mi3_pkg::t_cof [mi3_pkg::LANES-1:0]   r_cof_c;
    mi3_pkg::t_cof [mi3_pkg::LANES-1:0]   r_cof_d;
    mi3_pkg::t_det                        n_det;
    mi3_pkg::t_det                        r_det;
    logic                                 w_det_neg;
    mi3_pkg::t_den                        n_den;
    mi3_pkg::t_num [mi3_pkg::LANES-1:0]   n_num;
    logic [mi3_pkg::LANES-1:0]            n_neg;
    mi3_pkg::t_mag                        w_mag [mi3_pkg::LANES];
    mi3_pkg::t_den                        r_den;
    mi3_pkg::t_num [mi3_pkg::LANES-1:0]   r_num;
    logic [mi3_pkg::LANES-1:0]            r_neg;
    logic                                 r_zero;
    logic                                 r_vc;
    logic                                 r_vd;
    logic                                 r_ve;

    // Each row-0 cofactor is split into a signed upper half and an unsigned
    // lower half so that every multiplier stays near 33 by 33 bits.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_lo[j]  = $signed({1'b0, i_cof[3*j][mi3_pkg::ELEM_W-1:0]});
            w_hi[j]  = $signed(i_cof[3*j][mi3_pkg::COF_W-1:mi3_pkg::ELEM_W]);
            n_plo[j] = mi3_pkg::t_part'(i_row0[j]) * mi3_pkg::t_part'(w_lo[j]);
            n_phi[j] = mi3_pkg::t_part'(i_row0[j]) * mi3_pkg::t_part'(w_hi[j]);
        end
    end

    always_comb begin
        n_det = '0;
        for (int j = 0; j < 3; j++) begin
            n_det = n_det + (mi3_pkg::t_det'(r_phi[j]) <<< mi3_pkg::ELEM_W)
                          + mi3_pkg::t_det'(r_plo[j]);
        end
    end

    assign w_det_neg = r_det[mi3_pkg::DET_W-1];

    always_comb begin
        n_den = w_det_neg ? mi3_pkg::t_den'(-r_det) : mi3_pkg::t_den'(r_det);
        for (int l = 0; l < mi3_pkg::LANES; l++) begin
            w_mag[l] = r_cof_d[l][mi3_pkg::COF_W-1] ? mi3_pkg::t_mag'(-r_cof_d[l])
                                                    : mi3_pkg::t_mag'(r_cof_d[l]);
            n_num[l] = {w_mag[l], {(2*mi3_pkg::FRAC_W){1'b0}}};
            n_neg[l] = r_cof_d[l][mi3_pkg::COF_W-1] ^ w_det_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
        end else if (i_en) begin
            r_vc <= i_valid;
            r_vd <= r_vc;
            r_ve <= r_vd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_plo   <= n_plo;
            r_phi   <= n_phi;
            r_cof_c <= i_cof;
            r_det   <= n_det;
            r_cof_d <= r_cof_c;
            r_den   <= n_den;
            r_num   <= n_num;
            r_neg   <= n_neg;
            r_zero  <= (r_det == '0);
        end
    end

    assign o_valid = r_ve;
    assign o_den   = r_den;
    assign o_num   = r_num;
    assign o_neg   = r_neg;
    assign o_zero  = r_zero;

endmodule

[hw/rtl/mi3_divider.sv]
// ----------------------------------------------------------------------------
// mi3_divider
// Nine pipelined restoring dividers sharing one denominator; after a range
// check, one quotient bit per stage, then saturation into the result register.
// ----------------------------------------------------------------------------
module mi3_divider (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  logic                                    i_valid,
    input  mi3_pkg::t_den                           i_den,
    input  mi3_pkg::t_num [mi3_pkg::LANES-1:0]      i_num,
    input  logic [mi3_pkg::LANES-1:0]               i_neg,
    input  logic                                    i_zero,
    output logic                                    o_valid,
    output mi3_pkg::t_out_item                      o_item
);

    localparam mi3_pkg::t_quo LIM = mi3_pkg::t_quo'(1) << (mi3_pkg::ELEM_W - 1);
    localparam mi3_pkg::t_elem EMAX = mi3_pkg::t_elem'(LIM - mi3_pkg::t_quo'(1));
    localparam mi3_pkg::t_elem EMIN = mi3_pkg::t_elem'(LIM);

    logic [mi3_pkg::QB:0]                 r_v;
    mi3_pkg::t_den                        r_den  [mi3_pkg::QB+1];
    logic [mi3_pkg::LANES-1:0]            r_neg  [mi3_pkg::QB+1];
    logic [mi3_pkg::QB:0]                 r_zero;
    logic [mi3_pkg::LANES-1:0]            r_big  [mi3_pkg::QB+1];
    mi3_pkg::t_num [mi3_pkg::LANES-1:0]   r_rem  [mi3_pkg::QB+1];
    mi3_pkg::t_quo [mi3_pkg::LANES-1:0]   r_q    [mi3_pkg::QB+1];
    mi3_pkg::t_elem                       n_res  [mi3_pkg::LANES];
    logic                                 n_ovf;
    mi3_pkg::t_out_item                   n_item;
    mi3_pkg::t_out_item                   r_item;
    logic                                 r_vo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_v  <= {r_v[mi3_pkg::QB-1:0], i_valid};
            r_vo <= r_v[mi3_pkg::QB];
        end
    end

    for (genvar s = 0; s <= mi3_pkg::QB; s++) begin : g_step
        if (s == 0) begin : g_first
            // A quotient of 2^QB or more saturates whatever its low bits are.
            logic [mi3_pkg::LANES-1:0] n_big;
            always_comb begin
                for (int l = 0; l < mi3_pkg::LANES; l++) begin
                    n_big[l] = mi3_pkg::t_cmp'(i_num[l])
                            >= (mi3_pkg::t_cmp'(i_den) << mi3_pkg::QB);
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[0]  <= i_den;
                    r_neg[0]  <= i_neg;
                    r_zero[0] <= i_zero;
                    r_big[0]  <= n_big;
                    r_rem[0]  <= i_num;
                    r_q[0]    <= '0;
                end
            end
        end else begin : g_bit
            localparam int K = mi3_pkg::QB - s;
            mi3_pkg::t_cmp                        w_diff [mi3_pkg::LANES];
            mi3_pkg::t_num [mi3_pkg::LANES-1:0]   n_rem;
            mi3_pkg::t_quo [mi3_pkg::LANES-1:0]   n_q;
            always_comb begin
                for (int l = 0; l < mi3_pkg::LANES; l++) begin
                    w_diff[l] = mi3_pkg::t_cmp'(r_rem[s-1][l])
                              - (mi3_pkg::t_cmp'(r_den[s-1]) << K);
                    n_q[l]    = r_q[s-1][l];
                    if (!w_diff[l][mi3_pkg::CMP_W-1]) begin
                        n_rem[l]  = w_diff[l][mi3_pkg::NUM_W-1:0];
                        n_q[l][K] = 1'b1;
                    end else begin
                        n_rem[l]  = r_rem[s-1][l];
                    end
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[s]  <= r_den[s-1];
                    r_neg[s]  <= r_neg[s-1];
                    r_zero[s] <= r_zero[s-1];
                    r_big[s]  <= r_big[s-1];
                    r_rem[s]  <= n_rem;
                    r_q[s]    <= n_q;
                end
            end
        end
    end

    always_comb begin
        n_ovf = 1'b0;
        for (int l = 0; l < mi3_pkg::LANES; l++) begin
            if (r_neg[mi3_pkg::QB][l]) begin
                if (r_big[mi3_pkg::QB][l] || (r_q[mi3_pkg::QB][l] > LIM)) begin
                    n_res[l] = EMIN;
                    n_ovf    = 1'b1;
                end else begin
                    n_res[l] = -mi3_pkg::t_elem'(r_q[mi3_pkg::QB][l][mi3_pkg::ELEM_W-1:0]);
                end
            end else begin
                if (r_big[mi3_pkg::QB][l] || (r_q[mi3_pkg::QB][l] > (LIM - 1'b1))) begin
                    n_res[l] = EMAX;
                    n_ovf    = 1'b1;
                end else begin
                    n_res[l] = mi3_pkg::t_elem'(r_q[mi3_pkg::QB][l][mi3_pkg::ELEM_W-1:0]);
                end
            end
        end
        if (r_zero[mi3_pkg::QB]) begin
            n_item          = '0;
            n_item.singular = 1'b1;
        end else begin
            n_item.inv00    = n_res[0];
            n_item.inv01    = n_res[1];
            n_item.inv02    = n_res[2];
            n_item.inv10    = n_res[3];
            n_item.inv11    = n_res[4];
            n_item.inv12    = n_res[5];
            n_item.inv20    = n_res[6];
            n_item.inv21    = n_res[7];
            n_item.inv22    = n_res[8];
            n_item.singular = 1'b0;
            n_item.overflow = n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_vo;
    assign o_item  = r_item;

endmodule

[hw/rtl/matrix_inverse_3x3.sv]
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// Inverse of a signed Q16.16 3x3 matrix as adjugate over determinant.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Payload
//  input     in         i_in_valid / o_in_stall    i_in_data  (nine elements)
//  output    out        o_out_valid / i_out_stall  o_out_data (inverse, flags)
//
// One matrix is accepted per cycle while the output is not stalled. A result
// passes the input register, then the cofactor, determinant and divider stages.
// The divider: 34 stages, 33 of them one quotient bit each, for nine lanes at once.
// Reset is synchronous and active low; it clears all valid bits.
// The whole pipeline advances together and freezes only while the output
// register holds a result that is stalled, so the input then stalls too.
//
// ----------------------------------------------------------------------------
`include "matrix_inverse_3x3_macros.svh"

module matrix_inverse_3x3 (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  mi3_pkg::t_in_item     i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output mi3_pkg::t_out_item    o_out_data
);

    // Pipeline advance enable shared by every stage.
    logic                                 w_en;
    logic                                 r_in_valid;
    mi3_pkg::t_in_item                    r_in_item;

    logic                                 w_cof_valid;
    mi3_pkg::t_cof [mi3_pkg::LANES-1:0]   w_cof;
    mi3_pkg::t_elem [2:0]                 w_row0;

    logic                                 w_det_valid;
    mi3_pkg::t_den                        w_den;
    mi3_pkg::t_num [mi3_pkg::LANES-1:0]   w_num;
    logic [mi3_pkg::LANES-1:0]            w_neg;
    logic                                 w_zero;

    logic                                 w_all_zero;
    logic                                 w_any_sat;

    // Stages only hold when a finished result cannot leave.
    assign w_en       = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_en;

    // Input register: the accepted transaction enters here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_en) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_item <= i_in_data;
        end
    end

    // Pair products and the nine signed cofactors.
    mi3_cofactor u_cofactor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_in_valid),
        .i_item  (r_in_item),
        .o_valid (w_cof_valid),
        .o_cof   (w_cof),
        .o_row0  (w_row0)
    );

    // Determinant, then unsigned numerators, denominator and quotient signs.
    mi3_det u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cof_valid),
        .i_cof   (w_cof),
        .i_row0  (w_row0),
        .o_valid (w_det_valid),
        .o_den   (w_den),
        .o_num   (w_num),
        .o_neg   (w_neg),
        .o_zero  (w_zero)
    );

    // Bit-per-stage division, saturation and the output register.
    mi3_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_det_valid),
        .i_den   (w_den),
        .i_num   (w_num),
        .i_neg   (w_neg),
        .i_zero  (w_zero),
        .o_valid (o_out_valid),
        .o_item  (o_out_data)
    );

    // Helpers for the checks below.
    assign w_all_zero = (o_out_data.inv00 == '0) && (o_out_data.inv01 == '0)
                     && (o_out_data.inv02 == '0) && (o_out_data.inv10 == '0)
                     && (o_out_data.inv11 == '0) && (o_out_data.inv12 == '0)
                     && (o_out_data.inv20 == '0) && (o_out_data.inv21 == '0)
                     && (o_out_data.inv22 == '0);

    assign w_any_sat =
        (o_out_data.inv00[mi3_pkg::ELEM_W-2:0] == '0)
        || (o_out_data.inv00[mi3_pkg::ELEM_W-2:0] == '1)
        || (o_out_data.inv01[mi3_pkg::ELEM_W-2:0] == '0)
        || (o_out_data.inv01[mi3_pkg::ELEM_W-2:0] == '1)
        || (o_out_data.inv02[mi3_pkg::ELEM_W-2:0] == '0)
        || (o_out_data.inv02[mi3_pkg::ELEM_W-2:0] == '1)
        || (o_out_data.inv10[mi3_pkg::ELEM_W-2:0] == '0)
        || (o_out_data.inv10[mi3_pkg::ELEM_W-2:0] == '1)
        || (o_out_data.inv11[mi3_pkg::ELEM_W-2:0] == '0)
        || (o_out_data.inv11[mi3_pkg::ELEM_W-2:0] == '1)
        || (o_out_data.inv12[mi3_pkg::ELEM_W-2:0] == '0)
        || (o_out_data.inv12[mi3_pkg::ELEM_W-2:0] == '1)
        || (o_out_data.inv20[mi3_pkg::ELEM_W-2:0] == '0)
        || (o_out_data.inv20[mi3_pkg::ELEM_W-2:0] == '1)
        || (o_out_data.inv21[mi3_pkg::ELEM_W-2:0] == '0)
        || (o_out_data.inv21[mi3_pkg::ELEM_W-2:0] == '1)
        || (o_out_data.inv22[mi3_pkg::ELEM_W-2:0] == '0)
        || (o_out_data.inv22[mi3_pkg::ELEM_W-2:0] == '1);

    // A singular matrix yields all zeros and never an overflow.
    `MI3_ASSERT_SAME(a_singular_zero, i_clk, i_rst_n, o_out_valid && o_out_data.singular, w_all_zero && !o_out_data.overflow, "singular result not cleared")
    // An overflow flag needs at least one element at a saturation limit.
    `MI3_ASSERT_SAME(a_overflow_sat, i_clk, i_rst_n, o_out_valid && o_out_data.overflow, w_any_sat, "overflow without saturated element")
    // A frozen pipeline keeps the transaction held in the input register.
    `MI3_ASSERT_NEXT(a_hold_input, i_clk, i_rst_n, r_in_valid && !w_en, r_in_valid, "input stage lost a transaction")

endmodule
